[src/deq_pkg.sv]
// shared command codes, status codes and field widths of the double-ended queue
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 6;

   // command codes carried in the request tuser
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

   // status codes carried in the response tuser
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // response payload bundle held in the output register
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   data;
      logic [OCC_W-1:0]    occupancy;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

[src/deq_ram.sv]
// slot storage: one write port, one read port with registered read data
`default_nettype none

module deq_ram #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [deq_pkg::WORD_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [deq_pkg::WORD_W-1:0] rd_data
);

   logic [deq_pkg::WORD_W-1:0] mem [DEPTH];
   logic [deq_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/double_ended_queue_top.sv]
// top level of the bounded double-ended queue of signed 32-bit words
`default_nettype none

// Bounded double-ended queue kept as a ring of DEPTH words in one synchronous
// RAM (one write port, one read port, registered read data). Each request
// transfer carries a command in req_tuser and a word in req_tdata: push front,
// push back, pop front, pop back or dump. Every command yields at least one
// response transfer; the final one carries rsp_tlast. A push into a full queue
// is dropped with status full, a pop or dump of an empty queue reports empty,
// and unused command codes answer ok with data zero. Occupancy is the element
// count after the command, taken modulo 64. The block works on one command at a
// time: pushes, empty/full reports and unused codes load the response directly,
// pops first read the RAM slot and then load the response, and a dump streams
// one element per cycle from the RAM read port while the response port is not
// stalled. Slots need no clearing: only entries that hold pushed words are
// ever read. Writes and reads never fall in the same cycle, so a pop right
// after a push sees the written word without forwarding.
module double_ended_queue_top #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] cmd
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // [31:0] data, [37:32] occupancy, [39:38] zero
   output      logic [1:0]  rsp_tuser,   // [1:0] status
   output      logic        rsp_tlast
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > deq_pkg::OCC_W) ? CW : deq_pkg::OCC_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DUMP
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     dump_pos_ff, dump_pos_in;
   logic [CW-1:0]     dump_left_ff, dump_left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type  rsp_ff, rsp_in;

   // ram ports
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [deq_pkg::WORD_W-1:0] rd_data;

   logic [deq_pkg::CMD_W-1:0]  cmd;
   logic [deq_pkg::WORD_W-1:0] value;
   logic                       req_fire;
   logic                       rsp_free;
   logic                       is_full;
   logic                       is_empty;
   logic [AW-1:0]              front_dec;
   logic [AW-1:0]              front_inc;
   logic [AW-1:0]              back_pos;   // slot after the back element
   logic [AW-1:0]              tail_pos;   // slot of the back element
   logic [CW-1:0]              count_dec;

   // ring position of base + offset, offset at most DEPTH
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offset);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(offset);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] pos);
      return (pos == AW'(DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   // occupancy field is the count modulo 64
   function automatic logic [deq_pkg::OCC_W-1:0] occ_of(input logic [CW-1:0] cnt);
      logic [XW-1:0] wide;
      wide = XW'(cnt);
      return wide[deq_pkg::OCC_W-1:0];
   endfunction

   function automatic deq_pkg::rsp_type make_rsp(
         input logic [deq_pkg::STATUS_W-1:0] status,
         input logic [deq_pkg::WORD_W-1:0]   data,
         input logic [CW-1:0]                cnt,
         input logic                         last);
      deq_pkg::rsp_type r;
      r.status    = status;
      r.data      = data;
      r.occupancy = occ_of(cnt);
      r.last      = last;
      return r;
   endfunction

   assign cmd   = req_tuser;
   assign value = req_tdata;

   // a finished response may be taken in the same cycle a new one is loaded
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = ring_inc(front_ff);
   assign back_pos  = ring_add(front_ff, count_ff);
   assign tail_pos  = ring_add(front_ff, count_dec);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      dump_pos_in  = dump_pos_ff;
      dump_left_in = dump_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = back_pos;
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               case (cmd)
                  deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_in = make_rsp(deq_pkg::STATUS_FULL, '0, count_ff, 1'b1);
                     end else begin
                        wr_en = 1'b1;
                        if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                        count_in = count_ff + 1'b1;
                        rsp_in   = make_rsp(deq_pkg::STATUS_OK, '0, count_in, 1'b1);
                     end
                  end
                  deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
                     if (is_empty) begin
                        rsp_in = make_rsp(deq_pkg::STATUS_EMPTY, '0, count_ff, 1'b1);
                     end else begin
                        // response goes out once the slot has been read
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        rd_en        = 1'b1;
                        if (cmd == deq_pkg::CMD_POP_FRONT) begin
                           front_in = front_inc;
                        end else begin
                           rd_addr = tail_pos;
                        end
                        count_in = count_dec;
                        state_in = ST_POP;
                     end
                  end
                  deq_pkg::CMD_DUMP: begin
                     if (is_empty) begin
                        rsp_in = make_rsp(deq_pkg::STATUS_EMPTY, '0, count_ff, 1'b1);
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        rd_en        = 1'b1;
                        dump_pos_in  = front_inc;
                        dump_left_in = count_dec;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                     rsp_in = make_rsp(deq_pkg::STATUS_OK, '0, count_ff, 1'b1);
                  end
               endcase
            end
         end
         ST_POP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(deq_pkg::STATUS_OK, rd_data, count_ff, 1'b1);
               state_in     = ST_IDLE;
            end
         end
         ST_DUMP: begin
            // one element a cycle while the response port is free: emit the word the RAM read last, read the next
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(deq_pkg::STATUS_OK, rd_data, count_ff,
                                       dump_left_ff == '0);
               if (dump_left_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = dump_pos_ff;
                  dump_pos_in  = ring_inc(dump_pos_ff);
                  dump_left_in = dump_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dump_pos_ff  <= dump_pos_in;
      dump_left_ff <= dump_left_in;
      rsp_ff       <= rsp_in;
   end

   deq_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.occupancy, rsp_ff.data};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

endmodule

`default_nettype wire

[sim/deq_checker.sv]
// checker for the double-ended queue: watches both channels, predicts and compares responses
`timescale 1ns / 1ps

module deq_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] value
   input  logic [2:0]  req_tuser,    // [2:0] cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,    // [31:0] data, [37:32] occupancy, [39:38] zero
   input  logic [1:0]  rsp_tuser,    // [1:0] status
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          pending_count
);

   logic [deq_pkg::WORD_W-1:0] ring [DEPTH];
   int                         head;
   int                         fill;
   deq_pkg::rsp_type           expected_rsp [$];
   int                         errors = 0;

   assign mismatch_count = errors;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
   endtask

   function automatic void add_result(input logic [deq_pkg::STATUS_W-1:0] status,
                                      input logic [deq_pkg::WORD_W-1:0] data,
                                      input logic last_flag);
      deq_pkg::rsp_type r;
      r.status    = status;
      r.data      = data;
      r.occupancy = fill[deq_pkg::OCC_W-1:0];
      r.last      = last_flag;
      expected_rsp.push_back(r);
   endfunction

   // one command against the shadow ring, queuing every response it causes
   function automatic void apply_command(input logic [deq_pkg::CMD_W-1:0] cmd,
                                         input logic [deq_pkg::WORD_W-1:0] word);
      logic [deq_pkg::WORD_W-1:0] popped;
      case (cmd)
         deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               add_result(deq_pkg::STATUS_FULL, '0, 1'b1);
            end else begin
               if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  ring[head] = word;
               end else begin
                  ring[(head + fill) % DEPTH] = word;
               end
               fill++;
               add_result(deq_pkg::STATUS_OK, '0, 1'b1);
            end
         end
         deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
            if (fill == 0) begin
               add_result(deq_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (cmd == deq_pkg::CMD_POP_FRONT) begin
                  popped = ring[head];
                  head = (head + 1) % DEPTH;
               end else begin
                  popped = ring[(head + fill - 1) % DEPTH];
               end
               fill--;
               add_result(deq_pkg::STATUS_OK, popped, 1'b1);
            end
         end
         deq_pkg::CMD_DUMP: begin
            if (fill == 0) begin
               add_result(deq_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < fill; i++) begin
                  add_result(deq_pkg::STATUS_OK, ring[(head + i) % DEPTH], i == fill - 1);
               end
            end
         end
         default: add_result(deq_pkg::STATUS_OK, '0, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      deq_pkg::rsp_type want;
      if (reset) begin
         head = 0;
         fill = 0;
         expected_rsp.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with none pending", rsp_tdata[31:0], '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[31:0] != want.data)
                  report_mismatch("data", rsp_tdata[31:0], want.data);
               if (rsp_tdata[37:32] != want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_tdata[37:32]),
                                  32'(want.occupancy));
               if (rsp_tdata[39:38] != 2'b00)
                  report_mismatch("tdata pad", 32'(rsp_tdata[39:38]), '0);
               if (rsp_tlast != want.last)
                  report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            end
         end
      end
      pending_count <= expected_rsp.size();
   end

endmodule

[sim/testbench.sv]
// top of the double-ended queue testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 230;
   // no transfer for this many cycles means a hang
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 20;

   // codes the block does not use, sent as noise
   localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // [31:0] value
   logic [2:0]  req_tuser = '0;     // [2:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] data, [37:32] occupancy, [39:38] zero
   logic [1:0]  rsp_tuser;          // [1:0] status
   logic        rsp_tlast;

   int mismatch_count;
   int pending_count;
   int items_sent = 0;
   bit no_gaps = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   double_ended_queue_top #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   deq_checker #(.DEPTH(DEPTH)) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // response side backpressure: ready stretches, short stalls and a few long ones
   always @(posedge clock) begin
      int hold;
      int pick;
      if (reset) begin
         hold = 0;
         rsp_tready <= 1'b0;
      end else if (hold > 0) begin
         hold--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(1, 40);
         end else if (pick < 88) begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(10, 40);
         end
      end
   end

   // watchdog: counts cycles without any transfer on either channel
   always @(posedge clock) begin
      int idle;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly full-range random words, sometimes one of the extremes
   function automatic logic [31:0] pick_word();
      logic [31:0] extremes [5];
      extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001};
      if ($urandom_range(0, 99) < 12) return extremes[$urandom_range(0, 4)];
      return $urandom;
   endfunction

   // one request transfer; valid stays high when the next item follows without a gap
   task automatic send_cmd(input logic [deq_pkg::CMD_W-1:0] cmd, input logic [31:0] value);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_push(input logic [31:0] value);
      send_cmd($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT, value);
   endtask

   task automatic send_pop();
      send_cmd($urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT, $urandom);
   endtask

   // random mix of all commands, spare codes included as noise
   task automatic send_mixed(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 42) send_push(pick_word());
         else if (pick < 80) send_pop();
         else if (pick < 93) send_cmd(deq_pkg::CMD_DUMP, $urandom);
         else send_cmd(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), $urandom);
      end
   endtask

   initial begin
      int round;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reports first
      send_cmd(deq_pkg::CMD_DUMP, 32'h0);
      send_cmd(deq_pkg::CMD_POP_FRONT, 32'hffff_ffff);
      send_cmd(deq_pkg::CMD_POP_BACK, 32'h0);
      // extreme words at both ends
      send_cmd(deq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
      send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
      send_cmd(deq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
      send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
      send_cmd(deq_pkg::CMD_PUSH_BACK, 32'h5a5a_a5a5);
      send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'ha5a5_5a5a);
      send_cmd(deq_pkg::CMD_DUMP, 32'h1234_5678);
      send_cmd(deq_pkg::CMD_POP_FRONT, 32'h0);
      send_cmd(deq_pkg::CMD_POP_BACK, 32'h0);
      // spare codes answer ok and leave the queue alone
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
         send_cmd(3'(c), $urandom);
      end
      send_cmd(deq_pkg::CMD_DUMP, 32'h0);
      send_cmd(deq_pkg::CMD_POP_FRONT, 32'h0);
      send_cmd(deq_pkg::CMD_POP_BACK, 32'h0);
      send_cmd(deq_pkg::CMD_POP_FRONT, 32'h0);
      send_cmd(deq_pkg::CMD_POP_BACK, 32'h0);
      send_cmd(deq_pkg::CMD_DUMP, 32'h0);

      // random rounds: fill past full and dump, mixed, drain past empty, mixed, and again
      round = 0;
      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 2) == 0);
         case (round % 4)
            0: begin
               repeat (DEPTH + $urandom_range(1, 3)) send_push(pick_word());
               send_cmd(deq_pkg::CMD_DUMP, $urandom);
            end
            2: begin
               repeat (DEPTH + $urandom_range(1, 2)) send_pop();
            end
            default: send_mixed($urandom_range(8, 24));
         endcase
         round++;
      end
      req_tvalid <= 1'b0;

      // let the pending count catch up with the last transfer
      @(posedge clock);
      // wait out every pending response, then a few quiet cycles
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue_top.sv
sim/deq_checker.sv
sim/testbench.sv
